// ===== sv/upsmp_pkg.sv =====
// Shared types and constants for the horizontal 1331 upsampler.
package upsmp_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int SUM_BITS   = PIXEL_BITS + 3;
    localparam int AVG_BITS   = PIXEL_BITS + 1;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic       REG_SAT_THRESHOLD = 1'b0;
    localparam logic       REG_SAT_AWARE     = 1'b1;

    localparam logic [1:0] ROW_FULL  = 2'd3;
    localparam logic [1:0] ROW_TWO   = 2'd2;

    localparam logic [1:0] RUN_ONE   = 2'd1;
    localparam logic [1:0] RUN_TWO   = 2'd2;
    localparam logic [1:0] RUN_THREE = 2'd3;

    localparam logic [1:0] SEL_ORIG  = 2'd0;
    localparam logic [1:0] SEL_INTERP = 2'd1;
    localparam logic [1:0] SEL_TAIL  = 2'd2;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] threshold;
        logic                  aware;
    } t_cfg;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pix_a;
        logic [PIXEL_BITS-1:0] pix_b;
        logic [PIXEL_BITS-1:0] pix_c;
        logic [1:0]            n;
        logic                  eor;
        logic                  eof;
    } t_job;

endpackage

// ===== sv/upsmp_cfg.sv =====
// Configuration register file behind the APB-style port.
module upsmp_cfg
    import upsmp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (paddr[2])
                REG_SAT_THRESHOLD: n_cfg.threshold = pwdata[PIXEL_BITS-1:0];
                REG_SAT_AWARE:     n_cfg.aware     = pwdata[0];
                default:           n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= '1;
            r_cfg.aware     <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SAT_THRESHOLD: prdata = DATA_W'(r_cfg.threshold);
            REG_SAT_AWARE:     prdata = DATA_W'(r_cfg.aware);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/upsmp_front.sv =====
// Front end: window, saturation flags, row position and job classification.
module upsmp_front
    import upsmp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    input  logic                  i_eor,
    input  logic                  i_eof,
    input  logic                  i_full,
    output logic                  o_ready,
    output logic                  o_push,
    output t_job                  o_job
);

    logic [PIXEL_BITS-1:0] r_win [3];
    logic [2:0]            r_sat;
    logic [1:0]            r_pos;
    logic [1:0]            n_pos;

    logic                  accept;
    logic                  eor;
    logic                  s3;
    logic [SUM_BITS-1:0]   sum;
    logic [SUM_BITS-1:0]   sum_rnd;
    logic [AVG_BITS-1:0]   avg;
    logic [PIXEL_BITS-1:0] interp;
    logic [3:0]            sat_bits;

    assign o_ready = !i_full;
    assign accept  = i_valid & o_ready;
    assign eor     = i_eor | i_eof;
    assign s3      = (i_pixel >= i_cfg.threshold);

    assign sum = SUM_BITS'(r_win[0]) + SUM_BITS'({r_win[1], 1'b0}) + SUM_BITS'(r_win[1])
               + SUM_BITS'({r_win[2], 1'b0}) + SUM_BITS'(r_win[2]) + SUM_BITS'(i_pixel);
    assign sum_rnd  = sum + SUM_BITS'(4);
    assign avg      = AVG_BITS'(r_win[1]) + AVG_BITS'(r_win[2]) + AVG_BITS'(1);
    assign sat_bits = {s3, r_sat};

    always_comb begin
        if (!i_cfg.aware) begin
            interp = sum[SUM_BITS-1:3];
        end else if (sat_bits == 4'd0) begin
            interp = sum_rnd[SUM_BITS-1:3];
        end else begin
            case (sat_bits[2:1])
                2'b00:   interp = avg[AVG_BITS-1:1];
                2'b01:   interp = r_win[2];
                2'b10:   interp = r_win[1];
                default: interp = i_cfg.threshold;
            endcase
        end
    end

    always_comb begin
        o_job.pix_a = r_win[1];
        o_job.pix_b = interp;
        o_job.pix_c = r_win[2];
        o_job.eor   = eor;
        o_job.eof   = i_eof;
        o_job.n     = 2'd0;
        if (r_pos == ROW_FULL) begin
            o_job.n = eor ? RUN_THREE : RUN_TWO;
        end else if (eor) begin
            o_job.n     = RUN_ONE;
            o_job.pix_a = (r_pos == ROW_TWO) ? r_win[2] : i_pixel;
        end
    end

    assign o_push = accept & (o_job.n != 2'd0);

    always_comb begin
        if (eor) begin
            n_pos = 2'd0;
        end else if (r_pos != ROW_FULL) begin
            n_pos = r_pos + 2'd1;
        end else begin
            n_pos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= '0;
            r_win[1] <= '0;
            r_win[2] <= '0;
            r_sat    <= '0;
            r_pos    <= '0;
        end else if (accept) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= i_pixel;
            r_sat    <= {s3, r_sat[2:1]};
            r_pos    <= n_pos;
        end
    end

endmodule

// ===== sv/upsmp_fifo.sv =====
// Short job queue between the front end and the output sequencer.
module upsmp_fifo
    import upsmp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job              mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push & !o_full;
    assign do_pop  = i_pop & !o_empty;
    assign o_head  = mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/upsmp_back.sv =====
// Output sequencer: unrolls each job into its samples behind an output register.
module upsmp_back
    import upsmp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  t_job                  i_head,
    output logic                  o_pop,
    input  logic                  i_ready,
    output logic                  o_valid,
    output logic [PIXEL_BITS-1:0] o_pixel,
    output logic                  o_interp,
    output logic                  o_last_run,
    output logic                  o_row_done,
    output logic                  o_frame_done
);

    logic                  r_valid;
    logic [PIXEL_BITS-1:0] r_pixel;
    logic                  r_interp;
    logic                  r_last_run;
    logic                  r_row_done;
    logic                  r_frame_done;
    logic [1:0]            r_idx;

    logic                  slot_free;
    logic                  load;
    logic                  is_last;
    logic [PIXEL_BITS-1:0] sel_pix;
    logic                  sel_interp;

    assign slot_free = !r_valid | i_ready;
    assign load      = slot_free & !i_empty;
    assign is_last   = (r_idx == (i_head.n - 2'd1));
    assign o_pop     = load & is_last;

    always_comb begin
        case (r_idx)
            SEL_ORIG: begin
                sel_pix    = i_head.pix_a;
                sel_interp = 1'b0;
            end
            SEL_INTERP: begin
                sel_pix    = i_head.pix_b;
                sel_interp = 1'b1;
            end
            SEL_TAIL: begin
                sel_pix    = i_head.pix_c;
                sel_interp = 1'b0;
            end
            default: begin
                sel_pix    = i_head.pix_c;
                sel_interp = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pixel      <= sel_pix;
            r_interp     <= sel_interp;
            r_last_run   <= is_last;
            r_row_done   <= is_last & i_head.eor;
            r_frame_done <= is_last & i_head.eof;
        end
    end

    assign o_valid      = r_valid;
    assign o_pixel      = r_pixel;
    assign o_interp     = r_interp;
    assign o_last_run   = r_last_run;
    assign o_row_done   = r_row_done;
    assign o_frame_done = r_frame_done;

endmodule

// ===== sv/horizontal_1331_upsampler_unit.sv =====
// Horizontal 2x upsampler with a (1,3,3,1)/8 kernel, top level.
// A pixel request is taken whenever the two-entry job queue has room; the
// front end updates the window and builds the whole job for that pixel at
// once. The output register sends one sample per cycle while the receiver is
// ready, so the output port sets the sustained pixel rate; a pixel yields at
// most two samples, and a row-end pixel up to three. The first sample of an
// accepted pixel passes through the job queue entry and then the output
// register. In rows of four pixels or more the first and last pixels are
// dropped; a shorter row yields one sample.
module horizontal_1331_upsampler_unit
    import upsmp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_BITS-1:0] s_tdata,   // [15:0] pixel
    input  logic                  s_tlast,   // end_of_row
    input  logic                  s_tuser,   // [0] end_of_frame
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIXEL_BITS-1:0] m_tdata,   // [15:0] out_pixel
    output logic                  m_tlast,   // row_done
    output logic [2:0]            m_tuser,   // [0] is_interpolated, [1] last_of_run,
                                             // [2] frame_done
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    t_cfg cfg;
    t_job push_job;
    t_job head_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    upsmp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    upsmp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s_tvalid),
        .i_pixel (s_tdata),
        .i_eor   (s_tlast),
        .i_eof   (s_tuser),
        .i_full  (full),
        .o_ready (s_tready),
        .o_push  (push),
        .o_job   (push_job)
    );

    upsmp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_job)
    );

    upsmp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_head       (head_job),
        .o_pop        (pop),
        .i_ready      (m_tready),
        .o_valid      (m_tvalid),
        .o_pixel      (m_tdata),
        .o_interp     (m_tuser[0]),
        .o_last_run   (m_tuser[1]),
        .o_row_done   (m_tlast),
        .o_frame_done (m_tuser[2])
    );

endmodule

// ===== sv/upsmp_checker.sv =====
// Port-level checker for the upsampler, bound to the top level.
module upsmp_checker
    import upsmp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [PIXEL_BITS-1:0] m_tdata,
    input logic                  m_tlast,
    input logic [2:0]            m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output request changed while stalled");

    a_row_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("row end not on last sample of run");

    a_frame_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[2] |-> m_tlast)
        else $error("frame end without row end");

    a_interp_not_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |-> !m_tlast)
        else $error("interpolated sample closed a row");

endmodule

bind horizontal_1331_upsampler_unit upsmp_checker u_upsmp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== dv/tb_horizontal_1331_upsampler_unit.sv =====
// Self-checking testbench for the horizontal 1331 upsampler: pixel rows in, predicted samples out.
`timescale 1ns / 1ps
module tb_horizontal_1331_upsampler_unit;
    import upsmp_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int MAX_WAIT       = 18;
    localparam int REPORT_MAX     = 10;
    localparam int HOLD_CYCLES    = 120;
    localparam int PHASE_ITEMS    = 32;

    typedef logic [PIXEL_BITS-1:0] pix_t;

    typedef struct {
        pix_t pix;
        logic eor;
        logic eof;
    } pixel_req_t;

    typedef struct {
        pix_t pix;
        logic interp;
        logic run_end;
        logic row_end;
        logic frame_end;
    } sample_t;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    pix_t              s_tdata  = '0;   // [15:0] pixel
    logic              s_tlast  = 1'b0; // end_of_row
    logic              s_tuser  = 1'b0; // [0] end_of_frame
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    pix_t              m_tdata;         // [15:0] out_pixel
    logic              m_tlast;         // row_done
    logic [2:0]        m_tuser;         // [0] is_interpolated, [1] last_of_run, [2] frame_done
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0] pwdata   = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    horizontal_1331_upsampler_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    pixel_req_t pixel_q [$];
    sample_t    sample_q [$];

    pix_t       win [3]   = '{default: '0};
    logic [2:0] win_sat   = '0;
    logic [1:0] row_pos   = '0;
    pix_t       cfg_thr   = '1;
    logic       cfg_aware = 1'b1;

    bit         send_idle  = 1'b1;
    bit         recv_idle  = 1'b1;
    int         send_wait  = 0;
    int         recv_wait  = 0;
    pixel_req_t send_cur;
    int         n_accepted = 0;
    int         hold_at    = -1;
    int         hold_left  = 0;
    bit         hold_done  = 1'b0;
    int         quiet_cycles = 0;
    int         err_cnt    = 0;

    function automatic pix_t interp_1331(pix_t c3, logic s3);
        logic [SUM_BITS-1:0] sum;
        logic [AVG_BITS-1:0] avg;
        logic [3:0]          sat;
        sum = SUM_BITS'(win[0]) + SUM_BITS'(3 * win[1]) + SUM_BITS'(3 * win[2])
              + SUM_BITS'(c3);
        avg = AVG_BITS'((AVG_BITS'(win[1]) + AVG_BITS'(win[2]) + 1) >> 1);
        sat = {s3, win_sat};
        if (!cfg_aware)
            return pix_t'(sum >> 3);
        if (sat == '0)
            return pix_t'((sum + 4) >> 3);
        case (sat[2:1])
            2'b00:   return pix_t'(avg);
            2'b01:   return win[2];
            2'b10:   return win[1];
            default: return cfg_thr;
        endcase
    endfunction

    function automatic void push_sample(pix_t pix, logic interp);
        sample_t s;
        s = '{pix: pix, interp: interp, run_end: 1'b0, row_end: 1'b0, frame_end: 1'b0};
        sample_q.push_back(s);
    endfunction

    function automatic void upsample_pixel(pixel_req_t r);
        logic    row_end;
        logic    s3;
        int      first;
        sample_t tail;
        row_end = r.eor | r.eof;
        s3      = (r.pix >= cfg_thr);
        first   = sample_q.size();
        if (row_pos == ROW_FULL) begin
            push_sample(win[1], 1'b0);
            push_sample(interp_1331(r.pix, s3), 1'b1);
            if (row_end)
                push_sample(win[2], 1'b0);
        end else if (row_end) begin
            push_sample((row_pos == ROW_TWO) ? win[2] : r.pix, 1'b0);
        end
        if (sample_q.size() > first) begin
            tail           = sample_q.pop_back();
            tail.run_end   = 1'b1;
            tail.row_end   = row_end;
            tail.frame_end = r.eof;
            sample_q.push_back(tail);
        end
        win[0]  = win[1];
        win[1]  = win[2];
        win[2]  = r.pix;
        win_sat = {s3, win_sat[2:1]};
        if (row_end)
            row_pos = '0;
        else if (row_pos != ROW_FULL)
            row_pos = row_pos + 2'd1;
    endfunction

    function automatic int draw_wait(bit en);
        if (!en || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void note_mismatch(string what, sample_t e, sample_t g);
        err_cnt++;
        if (err_cnt <= REPORT_MAX)
            $display("%0t %s: expected pix=%h interp=%b run=%b row=%b frame=%b, %s",
                     $realtime, what, e.pix, e.interp, e.run_end, e.row_end, e.frame_end,
                     $sformatf("got pix=%h interp=%b run=%b row=%b frame=%b",
                               g.pix, g.interp, g.run_end, g.row_end, g.frame_end));
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            send_wait = 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                upsample_pixel(send_cur);
                n_accepted <= n_accepted + 1;
            end
            if (send_wait > 0) begin
                send_wait--;
                s_tvalid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                send_cur = pixel_q.pop_front();
                s_tdata  <= send_cur.pix;
                s_tlast  <= send_cur.eor;
                s_tuser  <= send_cur.eof;
                s_tvalid <= 1'b1;
                send_wait = draw_wait(send_idle);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        sample_t got;
        sample_t exp_s;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{pix: m_tdata, interp: m_tuser[0], run_end: m_tuser[1],
                        row_end: m_tlast, frame_end: m_tuser[2]};
                if (sample_q.size() == 0) begin
                    exp_s = '{pix: '0, interp: 1'b0, run_end: 1'b0, row_end: 1'b0,
                              frame_end: 1'b0};
                    note_mismatch("unexpected sample", exp_s, got);
                end else begin
                    exp_s = sample_q.pop_front();
                    if (got.pix !== exp_s.pix || got.interp !== exp_s.interp
                        || got.run_end !== exp_s.run_end || got.row_end !== exp_s.row_end
                        || got.frame_end !== exp_s.frame_end)
                        note_mismatch("sample mismatch", exp_s, got);
                end
                recv_wait = draw_wait(recv_idle);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (hold_left == 0);
            end
        end
    end

    // hold off the output for a long stretch, once
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && n_accepted == hold_at) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT - 1) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void push_px(pix_t pix, logic eor, logic eof);
        pixel_req_t r;
        r = '{pix: pix, eor: eor, eof: eof};
        pixel_q.push_back(r);
    endfunction

    function automatic pix_t pick_pixel(pix_t thr);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return thr + pix_t'($urandom_range(0, 2)) - pix_t'(1);
            default: return pix_t'($urandom);
        endcase
    endfunction

    function automatic void queue_rows(int n_items, pix_t thr);
        int   len;
        int   left;
        logic eof;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
            if (len > left)
                len = left;
            for (int k = 0; k < len - 1; k++)
                push_px(pick_pixel(thr), 1'b0, 1'b0);
            eof = (len == left) ? 1'b1 : ($urandom_range(0, 9) == 0);
            push_px(pick_pixel(thr), eof ? logic'($urandom_range(0, 1)) : 1'b1, eof);
            left -= len;
        end
    endfunction

    task automatic write_reg(logic idx, pix_t val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SAT_THRESHOLD)
            cfg_thr = val;
        else
            cfg_aware = val[0];
    endtask

    task automatic settle();
        do
            @(negedge i_clk);
        while (pixel_q.size() != 0 || s_tvalid || sample_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        pix_t thr_list [6];
        bit   aware_list [6];
        pix_t thr;
        thr_list   = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF};
        aware_list = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_px(16'hFFFF, 1'b1, 1'b0);
        push_px(16'h0000, 1'b0, 1'b0);
        push_px(16'h8001, 1'b1, 1'b0);
        push_px(16'h0010, 1'b0, 1'b0);
        push_px(16'h0020, 1'b0, 1'b0);
        push_px(16'h0030, 1'b1, 1'b0);
        push_px(16'h0000, 1'b0, 1'b0);
        push_px(16'hFFFF, 1'b0, 1'b0);
        push_px(16'h0010, 1'b0, 1'b0);
        push_px(16'h0020, 1'b0, 1'b0);
        push_px(16'hFFFF, 1'b1, 1'b0);
        push_px(16'h0005, 1'b0, 1'b0);
        push_px(16'h0006, 1'b0, 1'b0);
        push_px(16'hFFFF, 1'b0, 1'b0);
        push_px(16'h0007, 1'b0, 1'b1);
        repeat (3) push_px(16'hFFFF, 1'b0, 1'b0);
        push_px(16'hFFFF, 1'b1, 1'b1);

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            thr = (ph == 3) ? pix_t'($urandom) : thr_list[ph];
            write_reg(REG_SAT_THRESHOLD, thr);
            write_reg(REG_SAT_AWARE, pix_t'(aware_list[ph]));
            @(negedge i_clk);
            send_idle = (ph != 1 && ph != 3 && ph != 5);
            recv_idle = (ph != 2 && ph != 3 && ph != 5);
            if (ph == 5)
                hold_at = n_accepted + 6;
            queue_rows(PHASE_ITEMS, thr);
        end

        settle();
        if (err_cnt == 0 && sample_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/upsmp_pkg.sv
sv/upsmp_cfg.sv
sv/upsmp_front.sv
sv/upsmp_fifo.sv
sv/upsmp_back.sv
sv/horizontal_1331_upsampler_unit.sv
sv/upsmp_checker.sv
dv/tb_horizontal_1331_upsampler_unit.sv
